### design/cecau_pkg.sv
// cecau_pkg: shared constants, types and arithmetic helpers for the
// contrast enforcing color adjust pipeline. Depends on nothing.
`default_nettype none
package cecau_pkg;

  localparam int SEARCH_STEPS   = 24;
  localparam int LUMA_FRAC_BITS = 16;

  // widths that follow from the constants
  localparam int U_W    = SEARCH_STEPS + 1;
  localparam int TAB_W  = LUMA_FRAC_BITS + 1;
  localparam int LUMA_W = LUMA_FRAC_BITS + 14;
  localparam int CMP_W  = LUMA_W + 13;
  localparam int SQ_W   = 2 * LUMA_W;
  localparam int MIX_W  = SEARCH_STEPS + 11;

  localparam logic [LUMA_W-1:0] LUMA_OFF  = LUMA_W'(500) << LUMA_FRAC_BITS;
  localparam logic [SQ_W-1:0]   POLE_REF  = SQ_W'(5250000) << (2 * LUMA_FRAC_BITS);
  localparam logic [U_W-1:0]    U_ONE     = U_W'(1) << SEARCH_STEPS;
  localparam logic [MIX_W-1:0]  MIX_HALF  = MIX_W'(1) << (SEARCH_STEPS - 1);

  typedef enum logic [1:0] {
    OUT_MET   = 2'd0,
    OUT_BLEND = 2'd1,
    OUT_POLE  = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // raw input item
  typedef struct packed {
    rgb_t        cand;
    rgb_t        back;
    rgb_t        goal;
    logic [12:0] ratio;
  } raw_t;

  // item as it travels through the search
  typedef struct packed {
    rgb_t              cand;
    rgb_t              goal;
    logic [LUMA_W-1:0] yback;
    logic [12:0]       ratio;
    outcome_t          code;
    logic              black;
    logic [U_W-1:0]    lower;
    logic [U_W-1:0]    upper;
  } item_t;

  // result item
  typedef struct packed {
    rgb_t     color;
    outcome_t code;
  } res_t;

  typedef logic [TAB_W-1:0] lin_tab_t [256];

  // srgb linearization, round to nearest with ties upward
  function automatic lin_tab_t build_tab();
    lin_tab_t t;
    longint   num;
    real      v;
    real      x;
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) begin
        num  = ((longint'(10 * c)) <<< LUMA_FRAC_BITS) + 64'sd16473;
        t[c] = TAB_W'(num / 32946);
      end else begin
        v    = (40.0 * c + 561.0) / 10761.0;
        x    = $pow(v, 2.4) * (2.0 ** LUMA_FRAC_BITS);
        t[c] = TAB_W'($rtoi(x + 0.5));
      end
    end
    return t;
  endfunction

  localparam lin_tab_t LIN_TAB = build_tab();

  function automatic logic [LUMA_W-1:0] luma_of(rgb_t c);
    return LUMA_W'(14'd2126 * LUMA_W'(LIN_TAB[c.r]))
         + LUMA_W'(14'd7152 * LUMA_W'(LIN_TAB[c.g]))
         + LUMA_W'(14'd722  * LUMA_W'(LIN_TAB[c.b]));
  endfunction

  // 256*H >= ratio*L on offset luminances
  function automatic logic meets_ratio(logic [LUMA_W-1:0] ya, logic [LUMA_W-1:0] yb,
                                       logic [12:0] ratio);
    logic [LUMA_W-1:0] h;
    logic [LUMA_W-1:0] l;
    h = ((ya > yb) ? ya : yb) + LUMA_OFF;
    l = ((ya > yb) ? yb : ya) + LUMA_OFF;
    return (CMP_W'(h) << 8) >= (CMP_W'(ratio) * CMP_W'(l));
  endfunction

  function automatic logic [7:0] mix_chan(logic [7:0] s, logic [7:0] t, logic [U_W-1:0] u);
    logic signed [MIX_W-1:0] base;
    logic signed [MIX_W-1:0] diff;
    logic signed [MIX_W-1:0] acc;
    base = $signed(MIX_W'(s)) <<< SEARCH_STEPS;
    diff = $signed(MIX_W'(t)) - $signed(MIX_W'(s));
    acc  = base + diff * $signed(MIX_W'(u)) + $signed(MIX_HALF);
    return acc[SEARCH_STEPS+7:SEARCH_STEPS];
  endfunction

  function automatic rgb_t mix_color(rgb_t a, rgb_t b, logic [U_W-1:0] u);
    rgb_t o;
    o.r = mix_chan(a.r, b.r, u);
    o.g = mix_chan(a.g, b.g, u);
    o.b = mix_chan(a.b, b.b, u);
    return o;
  endfunction

endpackage
`default_nettype wire

### design/cecau_in_if.sv
// cecau_in_if: input channel, valid/ready with the candidate, background,
// goal colors and the required ratio. No dependencies.
`default_nettype none
interface cecau_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cand_red;
  logic [7:0]  cand_green;
  logic [7:0]  cand_blue;
  logic [7:0]  back_red;
  logic [7:0]  back_green;
  logic [7:0]  back_blue;
  logic [7:0]  goal_red;
  logic [7:0]  goal_green;
  logic [7:0]  goal_blue;
  logic [12:0] min_ratio_q8;

  modport source (output valid, cand_red, cand_green, cand_blue, back_red, back_green,
                  back_blue, goal_red, goal_green, goal_blue, min_ratio_q8, input ready);
  modport sink (input valid, cand_red, cand_green, cand_blue, back_red, back_green,
                back_blue, goal_red, goal_green, goal_blue, min_ratio_q8, output ready);
endinterface
`default_nettype wire

### design/cecau_out_if.sv
// cecau_out_if: result channel, valid/ready with adjusted color and outcome.
// No dependencies.
`default_nettype none
interface cecau_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [1:0] outcome;

  modport source (output valid, out_red, out_green, out_blue, outcome, input ready);
  modport sink (input valid, out_red, out_green, out_blue, outcome, output ready);
endinterface
`default_nettype wire

### design/cecau_front.sv
// cecau_front: luminance of candidate, background and goal, then the ratio
// checks and pole choice that decide the outcome. Uses cecau_pkg.
`default_nettype none
module cecau_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  cecau_pkg::raw_t      in_item,
  output logic                 out_valid,
  output cecau_pkg::item_t     out_item
);
  import cecau_pkg::*;

  logic              s1_valid;
  raw_t              s1_raw;
  logic [LUMA_W-1:0] s1_yb;
  logic [LUMA_W-1:0] s1_yc;
  logic [LUMA_W-1:0] s1_yg;

  logic              mc;
  logic              mg;
  logic [SQ_W-1:0]   sq;
  item_t             item_next;

  // stage 1: table lookups and weighted sums
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_raw <= in_item;
      s1_yb  <= luma_of(in_item.back);
      s1_yc  <= luma_of(in_item.cand);
      s1_yg  <= luma_of(in_item.goal);
    end
  end

  // stage 2: ratio tests, pole choice and search bounds
  always_comb begin
    mc = meets_ratio(s1_yc, s1_yb, s1_raw.ratio);
    mg = meets_ratio(s1_yg, s1_yb, s1_raw.ratio);
    sq = SQ_W'(s1_yb + LUMA_OFF) * SQ_W'(s1_yb + LUMA_OFF);
    item_next.cand  = s1_raw.cand;
    item_next.goal  = s1_raw.goal;
    item_next.yback = s1_yb;
    item_next.ratio = s1_raw.ratio;
    item_next.black = (sq >= POLE_REF);
    item_next.lower = '0;
    item_next.upper = U_ONE;
    priority if (mc) begin
      item_next.code = OUT_MET;
    end else if (!mg) begin
      item_next.code = OUT_POLE;
    end else begin
      item_next.code = OUT_BLEND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule
`default_nettype wire

### design/cecau_step.sv
// cecau_step: one bisection step in three stages: blend at the midpoint,
// luminance of the blend, ratio test and bound update. Uses cecau_pkg.
`default_nettype none
module cecau_step (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  cecau_pkg::item_t     in_item,
  output logic                 out_valid,
  output cecau_pkg::item_t     out_item
);
  import cecau_pkg::*;

  logic              a_valid;
  item_t             a_item;
  logic [U_W-1:0]    a_mid;
  rgb_t              a_trial;
  logic              b_valid;
  item_t             b_item;
  logic [U_W-1:0]    b_mid;
  logic [LUMA_W-1:0] b_y;
  logic [U_W:0]      mid_sum;
  logic [U_W-1:0]    mid;
  item_t             item_next;

  assign mid_sum = {1'b0, in_item.lower} + {1'b0, in_item.upper};
  assign mid     = mid_sum[U_W:1];

  // valid bits for the three stages
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

  // stage a: blend at the midpoint
  always_ff @(posedge clk) begin
    if (en) begin
      a_item  <= in_item;
      a_mid   <= mid;
      a_trial <= mix_color(in_item.cand, in_item.goal, mid);
    end
  end

  // stage b: luminance of the trial color
  always_ff @(posedge clk) begin
    if (en) begin
      b_item <= a_item;
      b_mid  <= a_mid;
      b_y    <= luma_of(a_trial);
    end
  end

  // stage c: ratio test moves one bound to the midpoint
  always_comb begin
    item_next = b_item;
    if (meets_ratio(b_y, b_item.yback, b_item.ratio)) begin
      item_next.upper = b_mid;
    end else begin
      item_next.lower = b_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule
`default_nettype wire

### design/cecau_out.sv
// cecau_out: final blend and result selection, then an output register with
// a skid entry that frees the pipeline from the result side. Uses cecau_pkg.
`default_nettype none
module cecau_out (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  cecau_pkg::item_t     in_item,
  output logic                 advance,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output cecau_pkg::res_t      out_res
);
  import cecau_pkg::*;

  logic  fin_valid;
  res_t  fin_res;
  res_t  res_next;
  logic  skid_valid;
  res_t  skid_res;
  logic  push;
  logic  pop;

  assign advance = !skid_valid;
  assign push    = advance && fin_valid;
  assign pop     = out_valid && out_ready;

  // result selection by outcome
  always_comb begin
    res_next.code = in_item.code;
    unique case (in_item.code)
      OUT_MET:   res_next.color = in_item.cand;
      OUT_BLEND: res_next.color = mix_color(in_item.cand, in_item.goal, in_item.upper);
      OUT_POLE:  res_next.color = in_item.black ? '0 : '1;
      default:   res_next.color = in_item.cand;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (advance) begin
      fin_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fin_res <= res_next;
    end
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      out_res <= skid_valid ? skid_res : fin_res;
    end else if (push) begin
      skid_res <= fin_res;
    end
  end

  // skid entry only fills behind a held result
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid full with empty output");
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid filled without a stall");
  a_pole_color: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.code == OUT_POLE) |->
      (out_res.color == '0 || out_res.color == '1))
    else $error("pole result is not black or white");
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.code == OUT_MET || out_res.code == OUT_BLEND ||
                   out_res.code == OUT_POLE))
    else $error("bad outcome code");

endmodule
`default_nettype wire

### design/contrast_enforcing_color_adjust_unit.sv
// contrast_enforcing_color_adjust_unit: top level, front classification,
// one three-stage unit per bisection step and the output buffer.
// Throughput: one item per cycle while ready is high; each step unit is fully pipelined.
// Ready drops only when the output register and its skid entry are both full.
// Reset (rst, synchronous) clears all valid bits; no state is kept between items.
`default_nettype none
module contrast_enforcing_color_adjust_unit (
  input  wire logic    clk,
  input  wire logic    rst,
  cecau_in_if.sink     in_ch,
  cecau_out_if.source  out_ch
);
  import cecau_pkg::*;

  logic  en;
  raw_t  raw;
  logic  chain_valid [SEARCH_STEPS+1];
  item_t chain_item  [SEARCH_STEPS+1];
  res_t  res;

  assign in_ch.ready = en;
  assign raw.cand  = '{r: in_ch.cand_red, g: in_ch.cand_green, b: in_ch.cand_blue};
  assign raw.back  = '{r: in_ch.back_red, g: in_ch.back_green, b: in_ch.back_blue};
  assign raw.goal  = '{r: in_ch.goal_red, g: in_ch.goal_green, b: in_ch.goal_blue};
  assign raw.ratio = in_ch.min_ratio_q8;

  cecau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_ch.valid),
    .in_item   (raw),
    .out_valid (chain_valid[0]),
    .out_item  (chain_item[0])
  );

  // bisection chain
  for (genvar i = 0; i < SEARCH_STEPS; i++) begin : g_step
    cecau_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_valid[i]),
      .in_item   (chain_item[i]),
      .out_valid (chain_valid[i+1]),
      .out_item  (chain_item[i+1])
    );
  end

  cecau_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain_valid[SEARCH_STEPS]),
    .in_item   (chain_item[SEARCH_STEPS]),
    .advance   (en),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.out_red   = res.color.r;
  assign out_ch.out_green = res.color.g;
  assign out_ch.out_blue  = res.color.b;
  assign out_ch.outcome   = res.code;

endmodule
`default_nettype wire
